FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is high.
`define CDA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define CDA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/cda_pkg.sv
`timescale 1ns / 1ps
package cda_pkg;

  // Default configuration
  localparam int COUNT_BITS_DEF = 16;
  localparam int MAX_YEAR_DEF   = 9999;

  // Field widths
  localparam int CNT_PORT_W = 16;
  localparam int DAY_W      = 5;
  localparam int MONTH_W    = 4;
  localparam int YEAR_W     = 14;

  // Calendar constants
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_LAST  = 5'd31;
  localparam logic [DAY_W-1:0]   DAY_SHORT = 5'd30;
  localparam logic [DAY_W-1:0]   DAY_FEB_L = 5'd29;
  localparam logic [DAY_W-1:0]   DAY_FEB_N = 5'd28;
  localparam logic [YEAR_W-1:0]  YEAR_DEF  = 14'd2000;

  // Reciprocal of 100: q = (y * 5243) >> 19 is exact for every 14-bit year
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam int PROD_W = YEAR_W + RECIP_W;
  localparam int QUOT_W = PROD_W - RECIP_SHIFT;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_ADD  = 2'd1,
    MODE_SUB  = 2'd2,
    MODE_NOP  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_CLAMPED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QUOT,
    S_LEAP,
    S_CHECK,
    S_STEP
  } state_t;

  // Sequencer to datapath
  typedef struct packed {
    logic latch;
    logic calc_q;
    logic calc_leap;
    logic check;
    logic step;
  } cda_ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic move;
    logic last;
    logic year_chg;
  } cda_stat_t;

  // Length of a month, given the leap flag of its year
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = DAY_SHORT;
      MONTH_FEB:               len = leap ? DAY_FEB_L : DAY_FEB_N;
      default:                 len = DAY_LAST;
    endcase
    return len;
  endfunction

endpackage

FILE: hdl/cda_ctrl.sv
`timescale 1ns / 1ps
module cda_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  cda_pkg::cda_stat_t  stat,
  output cda_pkg::cda_ctrl_t  ctrl,
  output logic                busy
);
  import cda_pkg::*;

  state_t state, state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Evaluate leap, then check a load or unused word, or walk month by month
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_QUOT;
      end
      S_QUOT: state_next = S_LEAP;
      S_LEAP: begin
        state_next = stat.move ? S_STEP : S_CHECK;
      end
      S_CHECK: state_next = S_IDLE;
      S_STEP: begin
        if (stat.last) begin
          state_next = S_IDLE;
        end else if (stat.year_chg) begin
          state_next = S_QUOT;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Drive datapath controls
  always_comb begin
    ctrl.latch     = (state == S_IDLE) && start;
    ctrl.calc_q    = (state == S_QUOT);
    ctrl.calc_leap = (state == S_LEAP);
    ctrl.check     = (state == S_CHECK);
    ctrl.step      = (state == S_STEP);
    busy           = (state != S_IDLE);
  end

endmodule

FILE: hdl/cda_dpath.sv
`timescale 1ns / 1ps
module cda_dpath #(
  parameter int COUNT_BITS = cda_pkg::COUNT_BITS_DEF,
  parameter int MAX_YEAR   = cda_pkg::MAX_YEAR_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  cda_pkg::cda_ctrl_t                 ctrl,
  input  logic [1:0]                         mode,
  input  logic [cda_pkg::DAY_W-1:0]          load_day,
  input  logic [cda_pkg::MONTH_W-1:0]        load_month,
  input  logic [cda_pkg::YEAR_W-1:0]         load_year,
  input  logic [cda_pkg::CNT_PORT_W-1:0]     day_count,
  output cda_pkg::cda_stat_t                 stat,
  output logic                               done,
  output logic [cda_pkg::DAY_W-1:0]          out_day,
  output logic [cda_pkg::MONTH_W-1:0]        out_month,
  output logic [cda_pkg::YEAR_W-1:0]         out_year,
  output logic [1:0]                         status
);
  import cda_pkg::*;

  localparam int CW = (COUNT_BITS < CNT_PORT_W) ? COUNT_BITS : CNT_PORT_W;
  localparam int EW = ((CW > DAY_W) ? CW : DAY_W) + 1;
  localparam logic [YEAR_W-1:0] YMAX = YEAR_W'(MAX_YEAR);
  localparam logic [YEAR_W-1:0] YRST = (MAX_YEAR < 2000) ? YEAR_W'(MAX_YEAR) : YEAR_DEF;

  mode_t                op;
  logic [DAY_W-1:0]     ld_day;
  logic [MONTH_W-1:0]   ld_month;
  logic [YEAR_W-1:0]    ld_year;
  logic [CW-1:0]        n;
  logic [QUOT_W-1:0]    q;
  logic                 leap;
  logic [DAY_W-1:0]     cur_day;
  logic [MONTH_W-1:0]   cur_month;
  logic [YEAR_W-1:0]    cur_year;
  status_t              st_r;
  logic                 done_r;

  logic [YEAR_W-1:0]    yt;
  logic [PROD_W-1:0]    prod;
  logic [YEAR_W:0]      y100;
  logic                 div100;
  logic                 leap_next;

  logic [DAY_W-1:0]     lim;
  logic [DAY_W-1:0]     room;
  logic [DAY_W-1:0]     len_prev;
  logic [EW-1:0]        n_ext;
  logic [EW-1:0]        room_ext;
  logic [EW-1:0]        d_ext;
  logic                 add_fit;
  logic                 sub_fit;
  logic                 ld_ok;
  logic                 finish;

  logic [DAY_W-1:0]     day_next;
  logic [MONTH_W-1:0]   month_next;
  logic [YEAR_W-1:0]    year_next;
  logic [CW-1:0]        n_next;
  logic                 last;
  logic                 year_chg;
  logic                 clamp;

  // Year under test: the load year for a load, else the stored year
  assign yt   = (op == MODE_LOAD) ? ld_year : cur_year;
  assign prod = PROD_W'(yt) * PROD_W'(RECIP_100);

  // Leap rule from the registered quotient by 100
  always_comb begin
    y100      = {1'b0, q, 6'b0} + {2'b0, q, 5'b0} + {5'b0, q, 2'b0};
    div100    = (y100 == {1'b0, yt});
    leap_next = (yt[1:0] == 2'b00) && (!div100 || (q[1:0] == 2'b00));
  end

  // Validate a load word
  always_comb begin
    ld_ok = (ld_month >= MONTH_JAN) && (ld_month <= MONTH_DEC) && (ld_year <= YMAX) &&
            (ld_day != '0) && (ld_day <= month_len(ld_month, leap));
  end

  // Shared step unit: one month boundary per cycle in the step state
  always_comb begin
    lim      = month_len(cur_month, leap);
    room     = lim - cur_day;
    len_prev = month_len(cur_month - 4'd1, leap);
    n_ext    = EW'(n);
    room_ext = EW'(room);
    d_ext    = EW'(cur_day);
    add_fit  = (n_ext <= room_ext);
    sub_fit  = (n_ext < d_ext);

    day_next   = cur_day;
    month_next = cur_month;
    year_next  = cur_year;
    n_next     = n;
    last       = 1'b0;
    year_chg   = 1'b0;
    clamp      = 1'b0;

    if (n == '0) begin
      last = 1'b1;
    end else if (op == MODE_ADD) begin
      if (add_fit) begin
        day_next = cur_day + DAY_W'(n_ext);
        last     = 1'b1;
      end else begin
        n_next = CW'(n_ext - room_ext - EW'(1));
        if (cur_month == MONTH_DEC) begin
          if (cur_year >= YMAX) begin
            day_next = DAY_LAST;
            clamp    = 1'b1;
            last     = 1'b1;
          end else begin
            year_next  = cur_year + 14'd1;
            month_next = MONTH_JAN;
            day_next   = DAY_FIRST;
            year_chg   = 1'b1;
          end
        end else begin
          month_next = cur_month + 4'd1;
          day_next   = DAY_FIRST;
        end
      end
    end else begin
      if (sub_fit) begin
        day_next = cur_day - DAY_W'(n_ext);
        last     = 1'b1;
      end else begin
        n_next = CW'(n_ext - d_ext);
        if (cur_month == MONTH_JAN) begin
          if (cur_year == '0) begin
            day_next = DAY_FIRST;
            clamp    = 1'b1;
            last     = 1'b1;
          end else begin
            year_next  = cur_year - 14'd1;
            month_next = MONTH_DEC;
            day_next   = DAY_LAST;
            year_chg   = 1'b1;
          end
        end else begin
          month_next = cur_month - 4'd1;
          day_next   = len_prev;
        end
      end
    end
  end

  assign stat.move     = (op == MODE_ADD) || (op == MODE_SUB);
  assign stat.last     = last;
  assign stat.year_chg = year_chg;
  assign finish        = ctrl.check || (ctrl.step && last);

  // Capture the input word and leap intermediates
  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      op       <= mode_t'(mode);
      ld_day   <= load_day;
      ld_month <= load_month;
      ld_year  <= load_year;
    end
    if (ctrl.calc_q) begin
      q <= prod[PROD_W-1:RECIP_SHIFT];
    end
    if (ctrl.calc_leap) begin
      leap <= leap_next;
    end
    if (ctrl.latch) begin
      n <= day_count[CW-1:0];
    end else if (ctrl.step) begin
      n <= n_next;
    end
  end

  // Hold the stored date
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_day   <= DAY_FIRST;
      cur_month <= MONTH_JAN;
      cur_year  <= YRST;
    end else if (ctrl.check && (op == MODE_LOAD) && ld_ok) begin
      cur_day   <= ld_day;
      cur_month <= ld_month;
      cur_year  <= ld_year;
    end else if (ctrl.step) begin
      cur_day   <= day_next;
      cur_month <= month_next;
      cur_year  <= year_next;
    end
  end

  // Strobe the result word and its status
  always_ff @(posedge clk) begin
    if (rst) begin
      done_r <= 1'b0;
      st_r   <= ST_OK;
    end else begin
      done_r <= finish;
      if (ctrl.check) begin
        st_r <= ((op == MODE_LOAD) && !ld_ok) ? ST_INVALID : ST_OK;
      end else if (ctrl.step && last) begin
        st_r <= clamp ? ST_CLAMPED : ST_OK;
      end
    end
  end

  assign done      = done_r;
  assign out_day   = cur_day;
  assign out_month = cur_month;
  assign out_year  = cur_year;
  assign status    = st_r;

endmodule

FILE: hdl/calendar_day_adder_unit.sv
`timescale 1ns / 1ps
// Channel   Handshake        Fields
// input     start / busy     mode, load_day, load_month, load_year, day_count
// result    done (strobe)    out_day, out_month, out_year, status
//
// A word is taken when start is high and busy is low; busy stays high until it finishes.
// Load and unused mode: busy for quotient, leap and check states. Add or subtract: quotient,
// leap, a step per month boundary plus a last one; each new year redoes quotient and leap.
// The result is shown for one cycle with done, in the first cycle that busy is low.
// rst is synchronous and gives 1 January 2000 (or MAX_YEAR if lower).
// The receiver cannot stall: done is a pulse and must be taken when it comes.
module calendar_day_adder_unit #(
  parameter int COUNT_BITS = cda_pkg::COUNT_BITS_DEF,
  parameter int MAX_YEAR   = cda_pkg::MAX_YEAR_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         mode,
  input  logic [cda_pkg::DAY_W-1:0]          load_day,
  input  logic [cda_pkg::MONTH_W-1:0]        load_month,
  input  logic [cda_pkg::YEAR_W-1:0]         load_year,
  input  logic [cda_pkg::CNT_PORT_W-1:0]     day_count,
  output logic                               done,
  output logic [cda_pkg::DAY_W-1:0]          out_day,
  output logic [cda_pkg::MONTH_W-1:0]        out_month,
  output logic [cda_pkg::YEAR_W-1:0]         out_year,
  output logic [1:0]                         status
);
  import cda_pkg::*;
  `include "assert_macros.svh"

  localparam logic [YEAR_W-1:0] YMAX_CHK = YEAR_W'(MAX_YEAR);

  cda_ctrl_t ctrl;
  cda_stat_t stat;
  logic      date_ok;

  // Sequencer
  cda_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // Date registers and shared step unit
  cda_dpath #(
    .COUNT_BITS (COUNT_BITS),
    .MAX_YEAR   (MAX_YEAR)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .mode       (mode),
    .load_day   (load_day),
    .load_month (load_month),
    .load_year  (load_year),
    .day_count  (day_count),
    .stat       (stat),
    .done       (done),
    .out_day    (out_day),
    .out_month  (out_month),
    .out_year   (out_year),
    .status     (status)
  );

  // Flag a stored date with month and day in range
  assign date_ok = (out_month >= MONTH_JAN) && (out_month <= MONTH_DEC) && (out_day != '0);

  // Checks
  `CDA_ASSERT(a_done_idle, clk, rst, done |-> !busy, "result strobe while still working")
  `CDA_ASSERT(a_accept_busy, clk, rst, (start && !busy) |=> busy, "accepted word did not start")
  `CDA_ASSERT(a_date_sane, clk, rst, done |-> date_ok, "stored date out of range")
  `CDA_ASSERT(a_year_range, clk, rst, done |-> (out_year <= YMAX_CHK), "stored year above limit")

endmodule
